/* rtl/dll_pkg.sv */
// Shared constants for the doubly linked list engine: capacity, widths,
// action codes and status codes. No dependencies.
`default_nettype none
package dll_pkg;
   localparam int CAPACITY = 16;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int VAL_W = 32;

   localparam logic [2:0] ACT_INS_TAIL = 3'd0;
   localparam logic [2:0] ACT_INS_HEAD = 3'd1;
   localparam logic [2:0] ACT_INS_POS  = 3'd2;
   localparam logic [2:0] ACT_LIST_FWD = 3'd3;
   localparam logic [2:0] ACT_LIST_BCK = 3'd4;
   localparam logic [2:0] ACT_DEL_TAIL = 3'd5;
   localparam logic [2:0] ACT_DEL_HEAD = 3'd6;
   localparam logic [2:0] ACT_DEL_POS  = 3'd7;

   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_EMPTY  = 2'd1;
   localparam logic [1:0] STS_BADPOS = 2'd2;
   localparam logic [1:0] STS_FULL   = 2'd3;
endpackage
`default_nettype wire

/* rtl/dll_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module dll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/doubly_linked_list_engine.sv */
// Doubly linked list engine top level: control sequencer and list state.
// Depends on dll_pkg and dll_ram.
//
// Usage: a request beat (req_action, req_item_value, req_position) is taken
// when req_valid and req_ready are both high. Each request produces one or
// more response beats (rsp_out_value, rsp_status, rsp_last); the final beat
// of a request has rsp_last set. Values, next links and previous links live
// in three RAMs with a registered read.
// Inserts at the head or tail, rejected requests and requests on an empty
// list answer in the cycle after acceptance; while rsp_ready stays high, one
// request per cycle. A positional insert walks pos-2 links, one RAM read per
// cycle, then writes the new node's links and, in S_LINK, its neighbours'
// links. A positional removal walks pos-1 links, then unlinks the node and
// answers; a head or tail removal unlinks without a walk. A listing gives
// count beats, one per cycle while rsp_ready stays high, after a first read.
// A new request is taken only when the sequencer is idle.
// Reset clears the list (empty, pointers zero) at once; RAM contents are not
// cleared. While rsp_ready is low the pending beat holds and listings pause.
`default_nettype none
module doubly_linked_list_engine (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [2:0]                      req_action,
   input  wire logic signed [dll_pkg::VAL_W-1:0] req_item_value,
   input  wire logic [7:0]                      req_position,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic signed [dll_pkg::VAL_W-1:0]      rsp_out_value,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_last
);
   import dll_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_LINK, S_LIST} state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic [CNT_W-1:0]     steps_ff, steps_in;
   logic [IDX_W-1:0]     n_ff, n_in;
   logic [IDX_W-1:0]     after_ff, after_in;
   logic                 fwd_ff, fwd_in;
   logic                 is_ins_ff, is_ins_in;
   logic [VAL_W-1:0]     value_ff, value_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CAPACITY-1:0]  used_ff, used_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0]     rd_addr;
   logic [VAL_W-1:0]     rd_val;
   logic [IDX_W-1:0]     rd_next, rd_prev;
   logic                 val_we, next_we, prev_we;
   logic [IDX_W-1:0]     val_wa, next_wa, prev_wa;
   logic [VAL_W-1:0]     val_wd;
   logic [IDX_W-1:0]     next_wd, prev_wd;

   logic [IDX_W-1:0]     free_idx;
   logic                 can_emit, accept;
   logic [8:0]           pos_ext, cnt_ext;
   logic [7:0]           pos_m1, pos_m2;
   logic [IDX_W-1:0]     link_sel;

   // Entry stores.
   dll_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
      .clock(clock), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_wd),
      .rd_addr(rd_addr), .rd_data(rd_val));
   dll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(rd_addr), .rd_data(rd_next));
   dll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev_ram (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(rd_addr), .rd_data(rd_prev));

   // Lowest unused slot.
   always_comb begin
      free_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && can_emit;
   assign accept    = req_valid && req_ready;
   assign pos_ext   = {1'b0, req_position};
   assign cnt_ext   = 9'(count_ff);
   assign pos_m1    = req_position - 8'd1;
   assign pos_m2    = req_position - 8'd2;
   assign link_sel  = fwd_ff ? rd_next : rd_prev;

   // Sequencer: decode, link walk, list updates and response beat.
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      n_in          = n_ff;
      after_in      = after_ff;
      fwd_in        = fwd_ff;
      is_ins_in     = is_ins_ff;
      value_in      = value_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr       = cur_ff;
      val_we  = 1'b0; val_wa  = '0; val_wd  = '0;
      next_we = 1'b0; next_wa = '0; next_wd = '0;
      prev_we = 1'b0; prev_wa = '0; prev_wd = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_value_in = '0;
               rsp_last_in  = 1'b1;
               case (req_action) inside
                  ACT_INS_TAIL, ACT_INS_HEAD, ACT_INS_POS: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_FULL;
                     end else if (req_action == ACT_INS_POS &&
                                  (req_position == 8'd0 || pos_ext > cnt_ext + 9'd1)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_BADPOS;
                     end else if (req_action == ACT_INS_POS && req_position != 8'd1 &&
                                  pos_ext != cnt_ext + 9'd1) begin
                        // Middle insert: walk to the node before the position.
                        n_in      = free_idx;
                        used_in   = used_ff | (CAPACITY'(1) << free_idx);
                        count_in  = count_ff + 1'b1;
                        value_in  = req_item_value;
                        cur_in    = head_ff;
                        rd_addr   = head_ff;
                        steps_in  = pos_m2[CNT_W-1:0];
                        is_ins_in = 1'b1;
                        state_in  = S_WALK;
                     end else begin
                        // Insert at an end, done in this cycle.
                        val_we   = 1'b1;
                        val_wa   = free_idx;
                        val_wd   = req_item_value;
                        used_in  = used_ff | (CAPACITY'(1) << free_idx);
                        count_in = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           head_in = free_idx;
                           tail_in = free_idx;
                        end else if (req_action == ACT_INS_HEAD ||
                                     (req_action == ACT_INS_POS && req_position == 8'd1)) begin
                           next_we = 1'b1; next_wa = free_idx; next_wd = head_ff;
                           prev_we = 1'b1; prev_wa = head_ff;  prev_wd = free_idx;
                           head_in = free_idx;
                        end else begin
                           prev_we = 1'b1; prev_wa = free_idx; prev_wd = tail_ff;
                           next_we = 1'b1; next_wa = tail_ff;  next_wd = free_idx;
                           tail_in = free_idx;
                        end
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_OK;
                     end
                  end
                  ACT_LIST_FWD, ACT_LIST_BCK: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        fwd_in   = (req_action == ACT_LIST_FWD);
                        cur_in   = (req_action == ACT_LIST_FWD) ? head_ff : tail_ff;
                        rd_addr  = (req_action == ACT_LIST_FWD) ? head_ff : tail_ff;
                        steps_in = count_ff;
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else if (req_action == ACT_DEL_POS &&
                                  (req_position == 8'd0 || pos_ext > cnt_ext)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_BADPOS;
                     end else begin
                        cur_in    = (req_action == ACT_DEL_TAIL) ? tail_ff : head_ff;
                        rd_addr   = (req_action == ACT_DEL_TAIL) ? tail_ff : head_ff;
                        steps_in  = (req_action == ACT_DEL_POS) ? pos_m1[CNT_W-1:0] : '0;
                        is_ins_in = 1'b0;
                        state_in  = S_WALK;
                     end
                  end
               endcase
            end
         end
         S_WALK: begin
            if (steps_ff != '0) begin
               // One link per cycle.
               cur_in   = rd_next;
               rd_addr  = rd_next;
               steps_in = steps_ff - 1'b1;
            end else if (is_ins_ff) begin
               // New node points at its neighbors.
               val_we  = 1'b1; val_wa  = n_ff; val_wd  = value_ff;
               next_we = 1'b1; next_wa = n_ff; next_wd = rd_next;
               prev_we = 1'b1; prev_wa = n_ff; prev_wd = cur_ff;
               after_in = rd_next;
               state_in = S_LINK;
            end else if (can_emit) begin
               // Unlink the node read this cycle and return its value.
               if (count_ff <= CNT_W'(1)) begin
                  head_in  = '0;
                  tail_in  = '0;
                  count_in = '0;
               end else begin
                  if (cur_ff == head_ff) begin
                     head_in = rd_next;
                  end else if (cur_ff == tail_ff) begin
                     tail_in = rd_prev;
                  end else begin
                     next_we = 1'b1; next_wa = rd_prev; next_wd = rd_next;
                     prev_we = 1'b1; prev_wa = rd_next; prev_wd = rd_prev;
                  end
                  count_in = count_ff - 1'b1;
               end
               used_in       = used_ff & ~(CAPACITY'(1) << cur_ff);
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_val;
               rsp_status_in = STS_OK;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_LINK: begin
            // Neighbors point at the new node.
            next_we = 1'b1; next_wa = cur_ff;   next_wd = n_ff;
            prev_we = 1'b1; prev_wa = after_ff; prev_wd = n_ff;
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STS_OK;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_LIST: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_val;
               rsp_status_in = STS_OK;
               rsp_last_in   = (steps_ff == CNT_W'(1));
               if (steps_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in   = link_sel;
                  rd_addr  = link_sel;
                  steps_in = steps_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      n_ff          <= n_in;
      after_ff      <= after_in;
      fwd_ff        <= fwd_in;
      is_ins_ff     <= is_ins_in;
      value_ff      <= value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;
endmodule
`default_nettype wire

/* verif/doubly_linked_list_engine_test.sv */
// Testbench for the doubly linked list engine: directed table, then random
// actions checked against a behavioral list model. Depends on dll_pkg and the RTL.
`timescale 1ns / 1ps
module doubly_linked_list_engine_test;
   import dll_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_action = ACT_INS_TAIL;
   logic signed [VAL_W-1:0] req_item_value = '0;
   logic [7:0] req_position = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [VAL_W-1:0] rsp_out_value;
   logic [1:0] rsp_status;
   logic rsp_last;

   doubly_linked_list_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_item_value(req_item_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_value(rsp_out_value), .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   always #1 clock = ~clock;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [1:0] status;
      logic last;
   } beat_type;

   typedef struct {
      logic [2:0] action;
      logic [VAL_W-1:0] item;
      logic [7:0] pos;
      bit typed;
      beat_type want;
   } row_type;

   // The list is modeled as an ordered queue of values, head first.
   logic [VAL_W-1:0] list_q[$];
   beat_type pending_beats[$];
   int errors = 0;
   int cycle_count = 0;
   int send_idle = 0;
   int recv_stall = 0;
   bit hold_off = 0;
   int hold_count = 0;

   // Computes the beats for one action and updates the modeled list.
   task automatic predict_action(input logic [2:0] act, input logic [VAL_W-1:0] val,
                                 input logic [7:0] pos);
      int n;
      beat_type b;
      n = list_q.size();
      b = '{value: '0, status: STS_OK, last: 1'b1};
      case (act)
         ACT_INS_TAIL, ACT_INS_HEAD, ACT_INS_POS: begin
            if (n >= CAPACITY) b.status = STS_FULL;
            else if (act == ACT_INS_TAIL) list_q.push_back(val);
            else if (act == ACT_INS_HEAD) list_q.push_front(val);
            else if (pos == 0 || pos > n + 1) b.status = STS_BADPOS;
            else list_q.insert(pos - 1, val);
            pending_beats.push_back(b);
         end
         ACT_LIST_FWD, ACT_LIST_BCK: begin
            if (n == 0) begin
               b.status = STS_EMPTY;
               pending_beats.push_back(b);
            end else begin
               for (int k = 0; k < n; k++) begin
                  b.value = (act == ACT_LIST_FWD) ? list_q[k] : list_q[n-1-k];
                  b.last = (k == n - 1);
                  pending_beats.push_back(b);
               end
            end
         end
         default: begin
            if (n == 0) b.status = STS_EMPTY;
            else if (act == ACT_DEL_TAIL) b.value = list_q.pop_back();
            else if (act == ACT_DEL_HEAD) b.value = list_q.pop_front();
            else if (pos == 0 || pos > n) b.status = STS_BADPOS;
            else begin
               b.value = list_q[pos-1];
               list_q.delete(pos - 1);
            end
            pending_beats.push_back(b);
         end
      endcase
   endtask

   // Offers one request beat and records its expected results on acceptance.
   // Valid drops only while the sender idles, so back-to-back beats keep it high.
   task automatic send_request(input logic [2:0] act, input logic [VAL_W-1:0] val,
                               input logic [7:0] pos);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_item_value <= val;
      req_position <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_action(act, val, pos);
   endtask

   // Receiver: random stalls, an optional long hold-off, and the beat checker.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_beats.size() == 0) begin
               $display("%0t unexpected beat: actual %h/%0d/%0d", $time,
                        rsp_out_value, rsp_status, rsp_last);
               errors++;
            end else begin
               beat_type w;
               w = pending_beats.pop_front();
               if (w.value !== rsp_out_value || w.status !== rsp_status
                   || w.last !== rsp_last) begin
                  $display("%0t mismatch: expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                           w.value, w.status, w.last, rsp_out_value, rsp_status, rsp_last);
                  errors++;
               end
            end
         end
         if (hold_off) begin
            hold_count <= hold_count + 1;
            rsp_ready <= 1'b0;
            if (hold_count >= 400) hold_off <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   row_type rows[$];

   function automatic row_type mk(input logic [2:0] a, input logic [VAL_W-1:0] v,
                                  input logic [7:0] p, input bit t, input beat_type w);
      row_type r;
      r.action = a; r.item = v; r.pos = p; r.typed = t; r.want = w;
      return r;
   endfunction

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(3))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      beat_type none;
      int size_now;
      logic [2:0] act;
      none = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty-list cases, extremes, positions, fill and drain.
      rows.push_back(mk(ACT_LIST_FWD, 0, 0, 1, '{0, STS_EMPTY, 1}));
      rows.push_back(mk(ACT_LIST_BCK, 0, 0, 1, '{0, STS_EMPTY, 1}));
      rows.push_back(mk(ACT_DEL_TAIL, 0, 0, 1, '{0, STS_EMPTY, 1}));
      rows.push_back(mk(ACT_DEL_HEAD, 0, 0, 1, '{0, STS_EMPTY, 1}));
      rows.push_back(mk(ACT_DEL_POS, 0, 1, 1, '{0, STS_EMPTY, 1}));
      rows.push_back(mk(ACT_INS_POS, 5, 0, 1, '{0, STS_BADPOS, 1}));
      rows.push_back(mk(ACT_INS_POS, 5, 2, 1, '{0, STS_BADPOS, 1}));
      rows.push_back(mk(ACT_INS_POS, 32'h8000_0000, 1, 1, '{0, STS_OK, 1}));
      rows.push_back(mk(ACT_DEL_HEAD, 0, 0, 1, '{32'h8000_0000, STS_OK, 1}));
      rows.push_back(mk(ACT_INS_TAIL, 32'h7fff_ffff, 0, 1, '{0, STS_OK, 1}));
      rows.push_back(mk(ACT_INS_HEAD, 32'hffff_ffff, 0, 0, none));
      rows.push_back(mk(ACT_INS_POS, 32'h1234_5678, 3, 0, none));
      rows.push_back(mk(ACT_INS_POS, 32'h0bad_cafe, 2, 0, none));
      rows.push_back(mk(ACT_LIST_FWD, 0, 0, 0, none));
      rows.push_back(mk(ACT_LIST_BCK, 0, 0, 0, none));
      rows.push_back(mk(ACT_DEL_POS, 0, 0, 1, '{0, STS_BADPOS, 1}));
      rows.push_back(mk(ACT_DEL_POS, 0, 255, 1, '{0, STS_BADPOS, 1}));
      rows.push_back(mk(ACT_DEL_POS, 0, 2, 0, none));
      rows.push_back(mk(ACT_DEL_TAIL, 0, 0, 0, none));
      rows.push_back(mk(ACT_DEL_POS, 0, 1, 0, none));
      rows.push_back(mk(ACT_DEL_HEAD, 0, 0, 0, none));

      // Walk the table: typed rows replace their one predicted beat.
      foreach (rows[i]) begin
         send_request(rows[i].action, rows[i].item, rows[i].pos);
         if (rows[i].typed) begin
            void'(pending_beats.pop_back());
            pending_beats.push_back(rows[i].want);
         end
      end

      // Fill to capacity, reject twice, then list.
      for (int i = 0; i < CAPACITY; i++) send_request(ACT_INS_HEAD, $urandom, 0);
      send_request(ACT_INS_POS, 1, 1);
      send_request(ACT_INS_TAIL, 1, 0);
      send_request(ACT_LIST_FWD, 0, 0);

      // Random phases with different idling mixes; one long receiver hold-off.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 54; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 54; hold_count <= 0; hold_off <= 1; end
            default: begin send_idle = 19; recv_stall = 19; end
         endcase
         for (int i = 0; i < 68; i++) begin
            size_now = list_q.size();
            // Inserts dominate while the list is short so that walks get long.
            if ($urandom_range(99) < (size_now < 8 ? 60 : 35))
               act = $urandom_range(2);
            else
               act = $urandom_range(7);
            send_request(act, rand_value(),
                         ($urandom_range(9) == 0) ? 8'($urandom) :
                         8'($urandom_range(size_now + 2)));
         end
      end

      req_valid <= 1'b0;
      send_idle = 0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

/* doubly_linked_list_engine.f */
rtl/dll_pkg.sv
rtl/dll_ram.sv
rtl/doubly_linked_list_engine.sv
verif/doubly_linked_list_engine_test.sv
